### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off by rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Types and constants shared by the insertion sorter and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic insert;      // place the broadcast item into the row this cycle
    logic shift_out;   // move every cell's content one step toward cell 0
    logic descending;  // sort direction in force for the insertion
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } sort_state_t;

endpackage

`default_nettype wire

### design/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable insertion sorter for sets of signed 32-bit values, built as a row
// of compare-and-shift cells with a drain path toward cell 0.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction
//  --------  ------------------------------------  ---------
//  input     in_valid, in_ready, value, last_in     in
//  output    out_valid, out_ready, sorted_value,    out
//            last_out, overflowed
//  config    cfg_we, cfg_wdata (descending)         in
//
//  An input item with room in the row is inserted in the cycle it is
//  accepted, so items of a set stream in at one per cycle. After the item
//  marked last, the row drains through cell 0 at one result per cycle while
//  out_ready is high, with the input blocked. The input reopens as soon as
//  the final value is loaded into the output register, even if it is not
//  yet taken. Reset (rst, synchronous) empties the row and clears the sticky
//  overflow flag and the direction; cell contents are not cleared.
//
`default_nettype none

module insertion_sorter #(
  parameter int CAPACITY = 64
) (
  input  wire                clk,
  input  wire                rst,
  // input items
  input  wire                in_valid,
  output logic               in_ready,
  input  isort_pkg::data_t   value,
  input  wire                last_in,
  // results
  output logic               out_valid,
  input  wire                out_ready,
  output isort_pkg::data_t   sorted_value,
  output logic               last_out,
  output logic               overflowed,
  // configuration
  input  wire                cfg_we,
  input  wire                cfg_wdata
);
  import isort_pkg::*;

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sort_state_t state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic overflow_seen, overflow_seen_next;
  logic descending;

  logic in_fire;
  logic has_room;
  logic drain_load;
  cell_ctrl_t ctrl;

  data_t cell_value [CAPACITY];
  logic  cell_above [CAPACITY];

  assign in_ready = (state == ST_FILL);
  assign in_fire  = in_valid && in_ready;
  assign has_room = (fill < CNT_W'(CAPACITY));
  // The output register is free when empty or being emptied this cycle.
  assign drain_load = (state == ST_DRAIN) && (!out_valid || out_ready);

  assign ctrl.insert     = in_fire && has_room;
  assign ctrl.shift_out  = drain_load;
  assign ctrl.descending = descending;

  // Sequencer: fill until the last item, then feed the output register
  // from cell 0 until the count runs out.
  always_comb begin
    state_next         = state;
    fill_next          = fill;
    overflow_seen_next = overflow_seen;
    case (state)
      ST_FILL: begin
        if (in_fire) begin
          if (has_room) begin
            fill_next = fill + CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (last_in) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_load) begin
          fill_next = fill - CNT_W'(1);
          if (fill == CNT_W'(1)) begin
            state_next         = ST_FILL;
            overflow_seen_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL;
      fill          <= '0;
      overflow_seen <= 1'b0;
      descending    <= 1'b0;
    end else begin
      state         <= state_next;
      fill          <= fill_next;
      overflow_seen <= overflow_seen_next;
      if (cfg_we) begin
        descending <= cfg_wdata;
      end
    end
  end

  // Output register: parts the draining row from the downstream consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_load) begin
      sorted_value <= cell_value[0];
      last_out     <= (fill == CNT_W'(1));
      overflowed   <= overflow_seen;
    end
  end

  // The row of cells. The "above" chain runs from the tail toward cell 0 and
  // marks where the new item lands: right after the last cell that stays.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_v, right_v;
    logic  above_l, above_r;

    if (i == 0) begin : g_head
      assign left_v  = '0;
      assign above_l = 1'b1;
    end else begin : g_body
      assign left_v  = cell_value[i-1];
      assign above_l = cell_above[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_value[i];
      assign above_r = 1'b0;
    end else begin : g_mid
      assign right_v = cell_value[i+1];
      assign above_r = cell_above[i+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .fresh       (value),
      .occupied    (CNT_W'(i) < fill),
      .may_fill    (CNT_W'(i) <= fill),
      .left_value  (left_v),
      .above_left  (above_l),
      .right_value (right_v),
      .above_right (above_r),
      .above       (cell_above[i]),
      .stored      (cell_value[i])
    );
  end

  // The count never passes the number of cells.
  `ASSERT_IMPL(a_fill_bound, 1'b1, fill <= CNT_W'(CAPACITY))
  // Draining always has at least one value left to send.
  `ASSERT_IMPL(a_drain_nonempty, state == ST_DRAIN, fill != '0)
  // A last item always starts the drain.
  `ASSERT_NEXT(a_last_starts_drain, in_fire && last_in, state == ST_DRAIN)
  // A drain load always presents a result on the next cycle.
  `ASSERT_NEXT(a_drain_presents, drain_load, out_valid)

endmodule

`default_nettype wire

### design/isort_cell.sv
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorting row: holds a value, compares it against the
// broadcast item and takes that item or a neighbor's data when the row moves.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_cell (
  input  wire                    clk,
  input  isort_pkg::cell_ctrl_t  ctrl,
  input  isort_pkg::data_t       fresh,
  input  wire                    occupied,
  input  wire                    may_fill,
  input  isort_pkg::data_t       left_value,
  input  wire                    above_left,
  input  isort_pkg::data_t       right_value,
  input  wire                    above_right,
  output logic                   above,
  output isort_pkg::data_t       stored
);
  import isort_pkg::*;

  logic goes_after;
  logic keep;

  // The stored value moves past the new one when it compares strictly beyond.
  assign goes_after = ctrl.descending ? (stored < fresh) : (stored > fresh);
  assign keep       = occupied && !goes_after;
  // True when this cell or any cell to its right stays in place.
  assign above      = keep || above_right;

  always_ff @(posedge clk) begin
    if (ctrl.insert && may_fill) begin
      if (!above_left) begin
        stored <= left_value;
      end else if (!above) begin
        stored <= fresh;
      end
    end else if (ctrl.shift_out) begin
      stored <= right_value;
    end
  end

endmodule

`default_nettype wire
